// ===== rtl/vmsr_pkg.sv =====
// ----------------------------------------------------------------------------
// vmsr_pkg
// shared types and constants of the guest msr register file
// ----------------------------------------------------------------------------
package vmsr_pkg;

  // operation codes
  localparam logic [1:0] FUNC_READ      = 2'd0;
  localparam logic [1:0] FUNC_WRITE     = 2'd1;
  localparam logic [1:0] FUNC_CHK_READ  = 2'd2;
  localparam logic [1:0] FUNC_CHK_WRITE = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOTSUP  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_SYSCALL_EN  = 3'd0;
  localparam logic [2:0] CFG_TSC_AUX_EN  = 3'd1;
  localparam logic [2:0] CFG_ADDR_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_DEBUGCTL_MSK = 3'd3;
  localparam logic [2:0] CFG_SMM_MODE    = 3'd4;
  localparam logic [2:0] CFG_PAGING_ON   = 3'd5;
  localparam logic [2:0] CFG_FS_BASE     = 3'd6;
  localparam logic [2:0] CFG_GS_BASE     = 3'd7;

  localparam logic [6:0] ADDR_WIDTH_RESET = 7'd48;

  // msr numbers
  localparam logic [31:0] IDX_SEP_CS       = 32'h0000_0174;
  localparam logic [31:0] IDX_SYSENTER_ESP = 32'h0000_0175;
  localparam logic [31:0] IDX_SYSENTER_EIP = 32'h0000_0176;
  localparam logic [31:0] IDX_DEBUGCTL     = 32'h0000_01d9;
  localparam logic [31:0] IDX_PAT          = 32'h0000_0277;
  localparam logic [31:0] IDX_EFER         = 32'hc000_0080;
  localparam logic [31:0] IDX_STAR         = 32'hc000_0081;
  localparam logic [31:0] IDX_LSTAR        = 32'hc000_0082;
  localparam logic [31:0] IDX_CSTAR        = 32'hc000_0083;
  localparam logic [31:0] IDX_SFMASK       = 32'hc000_0084;
  localparam logic [31:0] IDX_FS_BASE      = 32'hc000_0100;
  localparam logic [31:0] IDX_GS_BASE      = 32'hc000_0101;
  localparam logic [31:0] IDX_KGSBASE      = 32'hc000_0102;
  localparam logic [31:0] IDX_TSC_AUX      = 32'hc000_0103;

  // efer bits
  localparam int unsigned EFER_LME_BIT = 8;
  localparam int unsigned EFER_LMA_BIT = 10;
  localparam logic [63:0] EFER_LMA     = 64'h0000_0000_0000_0400;
  localparam logic [63:0] EFER_ALLOWED = 64'h0000_0000_0000_0d01;

  // configuration seen by the execution logic
  typedef struct packed {
    logic        syscall_en;
    logic        tsc_aux_en;
    logic [63:0] canon_mask;   // bits that must all match for a canonical address
    logic [63:0] debugctl_mask;
    logic        smm_mode;
    logic        paging_on;
    logic [63:0] fs_base;
    logic [63:0] gs_base;
  } cfg_t;

endpackage

// ===== rtl/vmsr_cfg.sv =====
// ----------------------------------------------------------------------------
// vmsr_cfg
// configuration registers, with the canonical mask derived at write time
// ----------------------------------------------------------------------------
module vmsr_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output vmsr_pkg::cfg_t      cfg
);

  vmsr_pkg::cfg_t cfg_q;

  // mask over bits [63:w-1], w clamped to 32..64; empty at 64 and above
  function automatic logic [63:0] canon_mask_of(input logic [6:0] w);
    logic [6:0] wc;
    logic [5:0] sh;
    begin
      wc = (w < 7'd32) ? 7'd32 : w;
      sh = 6'(wc - 7'd1);
      canon_mask_of = (wc >= 7'd64) ? 64'd0 : ({64{1'b1}} << sh);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.syscall_en    <= 1'b0;
      cfg_q.tsc_aux_en    <= 1'b0;
      cfg_q.canon_mask    <= canon_mask_of(vmsr_pkg::ADDR_WIDTH_RESET);
      cfg_q.debugctl_mask <= '0;
      cfg_q.smm_mode      <= 1'b0;
      cfg_q.paging_on     <= 1'b0;
      cfg_q.fs_base       <= '0;
      cfg_q.gs_base       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vmsr_pkg::CFG_SYSCALL_EN:   cfg_q.syscall_en    <= cfg_data[0];
        vmsr_pkg::CFG_TSC_AUX_EN:   cfg_q.tsc_aux_en    <= cfg_data[0];
        vmsr_pkg::CFG_ADDR_WIDTH:   cfg_q.canon_mask    <= canon_mask_of(cfg_data[6:0]);
        vmsr_pkg::CFG_DEBUGCTL_MSK: cfg_q.debugctl_mask <= cfg_data;
        vmsr_pkg::CFG_SMM_MODE:     cfg_q.smm_mode      <= cfg_data[0];
        vmsr_pkg::CFG_PAGING_ON:    cfg_q.paging_on     <= cfg_data[0];
        vmsr_pkg::CFG_FS_BASE:      cfg_q.fs_base       <= cfg_data;
        vmsr_pkg::CFG_GS_BASE:      cfg_q.gs_base       <= cfg_data;
        default:                    cfg_q.syscall_en    <= cfg_q.syscall_en;
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule

// ===== rtl/vmsr_exec.sv =====
// ----------------------------------------------------------------------------
// vmsr_exec
// msr decode, value checks and the guest register state
// ----------------------------------------------------------------------------
module vmsr_exec (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [1:0]      func,
  input  logic [31:0]     msr_index,
  input  logic [63:0]     write_value,
  input  logic            smm_flag,
  input  vmsr_pkg::cfg_t  cfg,
  output logic [1:0]      status,
  output logic [63:0]     read_data
);

  logic [31:0] sep_cs_reg;
  logic [63:0] sysenter_esp_reg, sysenter_eip_reg, debugctl_reg, pat_reg, efer_reg;
  logic [63:0] star_reg, lstar_reg, cstar_reg, sfmask_reg, kgsbase_reg, tsc_aux_reg;

  logic hit_cs, hit_esp, hit_eip, hit_dbg, hit_pat, hit_efer;
  logic hit_star, hit_lstar, hit_cstar, hit_sfmask, hit_fs, hit_gs, hit_kgs, hit_tsc;
  logic present_wr, present_rd, present_chk;
  logic canon_ok, pat_ok, value_ok, do_write;
  logic [63:0] canon_bits, rd_mux;

  assign hit_cs     = (msr_index == vmsr_pkg::IDX_SEP_CS);
  assign hit_esp    = (msr_index == vmsr_pkg::IDX_SYSENTER_ESP);
  assign hit_eip    = (msr_index == vmsr_pkg::IDX_SYSENTER_EIP);
  assign hit_dbg    = (msr_index == vmsr_pkg::IDX_DEBUGCTL);
  assign hit_pat    = (msr_index == vmsr_pkg::IDX_PAT);
  assign hit_efer   = (msr_index == vmsr_pkg::IDX_EFER);
  assign hit_star   = (msr_index == vmsr_pkg::IDX_STAR);
  assign hit_lstar  = (msr_index == vmsr_pkg::IDX_LSTAR);
  assign hit_cstar  = (msr_index == vmsr_pkg::IDX_CSTAR);
  assign hit_sfmask = (msr_index == vmsr_pkg::IDX_SFMASK);
  assign hit_fs     = (msr_index == vmsr_pkg::IDX_FS_BASE);
  assign hit_gs     = (msr_index == vmsr_pkg::IDX_GS_BASE);
  assign hit_kgs    = (msr_index == vmsr_pkg::IDX_KGSBASE);
  assign hit_tsc    = (msr_index == vmsr_pkg::IDX_TSC_AUX);

  // every writable index has storage, so write presence covers both
  assign present_wr = hit_cs | hit_esp | hit_eip | hit_dbg | hit_pat | hit_efer
                    | (cfg.syscall_en & (hit_star | hit_lstar | hit_cstar
                                         | hit_sfmask | hit_kgs))
                    | (cfg.tsc_aux_en & hit_tsc);
  assign present_rd  = present_wr | hit_fs | hit_gs;
  assign present_chk = (func == vmsr_pkg::FUNC_CHK_WRITE) ? present_wr : present_rd;

  assign canon_bits = write_value & cfg.canon_mask;
  assign canon_ok   = (canon_bits == 64'd0) || (canon_bits == cfg.canon_mask);

  // memory types 2, 3 and above 7 are reserved
  always_comb begin
    pat_ok = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (write_value[8*i+3 +: 5] != 5'd0 || write_value[8*i+1 +: 2] == 2'b01) begin
        pat_ok = 1'b0;
      end
    end
  end

  always_comb begin
    value_ok = 1'b1;
    if (hit_sfmask || hit_tsc) begin
      value_ok = (write_value[63:32] == 32'd0);
    end else if (hit_esp || hit_eip || hit_lstar || hit_cstar || hit_kgs) begin
      value_ok = canon_ok;
    end else if (hit_dbg) begin
      value_ok = ((write_value & ~cfg.debugctl_mask) == 64'd0);
    end else if (hit_pat) begin
      value_ok = pat_ok;
    end else if (hit_efer) begin
      value_ok = ((write_value & ~vmsr_pkg::EFER_ALLOWED) == 64'd0)
               && !(cfg.paging_on && (write_value[vmsr_pkg::EFER_LME_BIT]
                                      != efer_reg[vmsr_pkg::EFER_LME_BIT]));
    end
  end

  assign rd_mux = ({64{hit_cs}}     & {32'd0, sep_cs_reg})
                | ({64{hit_esp}}    & sysenter_esp_reg)
                | ({64{hit_eip}}    & sysenter_eip_reg)
                | ({64{hit_dbg}}    & debugctl_reg)
                | ({64{hit_pat}}    & pat_reg)
                | ({64{hit_efer}}   & efer_reg)
                | ({64{hit_star}}   & star_reg)
                | ({64{hit_lstar}}  & lstar_reg)
                | ({64{hit_cstar}}  & cstar_reg)
                | ({64{hit_sfmask}} & sfmask_reg)
                | ({64{hit_fs}}     & cfg.fs_base)
                | ({64{hit_gs}}     & cfg.gs_base)
                | ({64{hit_kgs}}    & kgsbase_reg)
                | ({64{hit_tsc}}    & tsc_aux_reg);

  always_comb begin
    status    = vmsr_pkg::ST_OK;
    read_data = 64'd0;
    do_write  = 1'b0;
    unique case (func)
      vmsr_pkg::FUNC_READ: begin
        if (present_rd) read_data = rd_mux;
        else status = vmsr_pkg::ST_INVALID;
      end
      vmsr_pkg::FUNC_WRITE: begin
        if (present_wr && value_ok) do_write = 1'b1;
        else status = vmsr_pkg::ST_INVALID;
      end
      default: begin
        priority if (smm_flag != cfg.smm_mode) begin
          status = vmsr_pkg::ST_INVALID;
        end else if (!present_chk) begin
          status = vmsr_pkg::ST_NOTSUP;
        end else if (func == vmsr_pkg::FUNC_CHK_WRITE && !value_ok) begin
          status = vmsr_pkg::ST_INVALID;
        end else begin
          status = vmsr_pkg::ST_OK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_cs_reg       <= '0;
      sysenter_esp_reg <= '0;
      sysenter_eip_reg <= '0;
      debugctl_reg     <= '0;
      pat_reg          <= '0;
      efer_reg         <= '0;
      star_reg         <= '0;
      lstar_reg        <= '0;
      cstar_reg        <= '0;
      sfmask_reg       <= '0;
      kgsbase_reg      <= '0;
      tsc_aux_reg      <= '0;
    end else if (fire && do_write) begin
      if (hit_cs)     sep_cs_reg       <= write_value[31:0];
      if (hit_esp)    sysenter_esp_reg <= write_value;
      if (hit_eip)    sysenter_eip_reg <= write_value;
      if (hit_dbg)    debugctl_reg     <= write_value;
      if (hit_pat)    pat_reg          <= write_value;
      // lma is owned by the cpu, the guest write keeps it
      if (hit_efer)   efer_reg <= (write_value & ~vmsr_pkg::EFER_LMA)
                                | (efer_reg & vmsr_pkg::EFER_LMA);
      if (hit_star)   star_reg         <= write_value;
      if (hit_lstar)  lstar_reg        <= write_value;
      if (hit_cstar)  cstar_reg        <= write_value;
      if (hit_sfmask) sfmask_reg       <= write_value;
      if (hit_kgs)    kgsbase_reg      <= write_value;
      if (hit_tsc)    tsc_aux_reg      <= write_value;
    end
  end

  a_sfmask_upper_zero: assert property (@(posedge clk) disable iff (rst)
    sfmask_reg[63:32] == 32'd0 && tsc_aux_reg[63:32] == 32'd0)
    else $error("sfmask or tsc_aux holds upper bits");

  a_efer_reserved_zero: assert property (@(posedge clk) disable iff (rst)
    (efer_reg & ~vmsr_pkg::EFER_ALLOWED) == 64'd0)
    else $error("efer holds reserved bits");

  a_efer_lma_kept: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> efer_reg[vmsr_pkg::EFER_LMA_BIT] == $past(efer_reg[vmsr_pkg::EFER_LMA_BIT]))
    else $error("efer lma changed by a write");

  a_lme_locked: assert property (@(posedge clk) disable iff (rst)
    (cfg.paging_on && fire) |=> efer_reg[vmsr_pkg::EFER_LME_BIT]
                                == $past(efer_reg[vmsr_pkg::EFER_LME_BIT]))
    else $error("efer lme changed while paging is on");

endmodule

// ===== rtl/virtual_msr_register_file_top.sv =====
// ----------------------------------------------------------------------------
// virtual_msr_register_file_top
// guest model-specific register file with stream input and output
// ----------------------------------------------------------------------------
// Each input beat is one msr access (read, write, check read, check write)
// and produces exactly one output beat with a status and read data. An access
// is taken into an input register, decoded and checked combinationally,
// and its result lands in an output register at the same edge that a write
// updates the register state, so the next access already sees it. Throughput
// is one access per clock while m_tready does not stall the output. The input
// side keeps taking beats while a result waits in the output register, as
// long as the input register is empty. Configuration (register enables,
// address width, debugctl mask, smm mode, paging, fs/gs base) is written
// through cfg_we/cfg_index/cfg_data and should only change while no access is
// in flight. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module virtual_msr_register_file_top (
  input  logic          clk,
  input  logic          rst,

  // configuration write port
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,

  // access input
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [103:0]  s_tdata,   // func[1:0], msr_index[33:2], write_value[97:34], zero pad
  input  logic          s_tuser,   // smm_flag

  // result output
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [71:0]   m_tdata    // status[1:0], read_data[65:2], zero pad
);

  vmsr_pkg::cfg_t cfg;

  // input register
  logic        in_valid;
  logic [1:0]  in_func;
  logic [31:0] in_index;
  logic [63:0] in_value;
  logic        in_smm;

  // output register
  logic        out_valid;
  logic [1:0]  out_status;
  logic [63:0] out_data;

  logic        out_load, fire, s_beat;
  logic [1:0]  exec_status;
  logic [63:0] exec_data;

  assign out_load = !out_valid || m_tready;
  assign fire     = in_valid && out_load;
  assign s_tready = !in_valid || out_load;
  assign s_beat   = s_tvalid && s_tready;

  vmsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vmsr_exec u_exec (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .func        (in_func),
    .msr_index   (in_index),
    .write_value (in_value),
    .smm_flag    (in_smm),
    .cfg         (cfg),
    .status      (exec_status),
    .read_data   (exec_data)
  );

  // input stage: control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_beat) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  // input stage: payload
  always_ff @(posedge clk) begin
    if (s_beat) begin
      in_func  <= s_tdata[1:0];
      in_index <= s_tdata[33:2];
      in_value <= s_tdata[97:34];
      in_smm   <= s_tuser;
    end
  end

  // output stage: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // output stage: payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= exec_status;
      out_data   <= exec_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_data, out_status};

  a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without a full pipe");

  a_status_code_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == vmsr_pkg::ST_OK || out_status == vmsr_pkg::ST_INVALID
                   || out_status == vmsr_pkg::ST_NOTSUP))
    else $error("unknown status code");

  a_data_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != vmsr_pkg::ST_OK) |-> out_data == 64'd0)
    else $error("read data on a failed access");

  a_fire_moves_item: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed access produced no result");

endmodule

// ===== verif/tb_virtual_msr_register_file_top.sv =====
// ----------------------------------------------------------------------------
// tb_virtual_msr_register_file_top
// self-checking stream testbench for the guest msr register file
// ----------------------------------------------------------------------------
// A table of directed accesses runs first, under the reset configuration. It
// covers absent, read-only and gated indices, canonical, pat, debugctl and
// efer value checks, and smm mismatch on the check operations. Eight random
// phases follow, each under its own configuration. Among them are address
// widths at and beyond both ends of the range, masks and bases of all zeros
// and all ones, and paging locking efer.lme. Each accepted access is run
// through a local model of the register file, and its predicted or typed
// result is queued. Each output beat is compared against the oldest queued one.
// ----------------------------------------------------------------------------
module tb_virtual_msr_register_file_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  // every msr number the block decodes, for well-formed random accesses
  localparam logic [31:0] KNOWN_MSRS [14] = '{
    vmsr_pkg::IDX_SEP_CS, vmsr_pkg::IDX_SYSENTER_ESP, vmsr_pkg::IDX_SYSENTER_EIP,
    vmsr_pkg::IDX_DEBUGCTL, vmsr_pkg::IDX_PAT, vmsr_pkg::IDX_EFER, vmsr_pkg::IDX_STAR,
    vmsr_pkg::IDX_LSTAR, vmsr_pkg::IDX_CSTAR, vmsr_pkg::IDX_SFMASK,
    vmsr_pkg::IDX_FS_BASE, vmsr_pkg::IDX_GS_BASE, vmsr_pkg::IDX_KGSBASE,
    vmsr_pkg::IDX_TSC_AUX
  };

  // memory types a pat byte may hold
  localparam logic [7:0] PAT_TYPES [6] = '{8'd0, 8'd1, 8'd4, 8'd5, 8'd6, 8'd7};

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] idx;
    logic [63:0] val;
    logic        smm;
  } msr_access_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] data;
  } msr_result_t;

  typedef struct {
    msr_access_t acc;
    bit          typed;
    msr_result_t want;
  } directed_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_index = '0;
  logic [63:0]   cfg_data = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [103:0]  s_tdata = '0;   // func[1:0], msr_index[33:2], write_value[97:34], zero pad
  logic          s_tuser = 1'b0; // smm_flag
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [71:0]   m_tdata;        // status[1:0], read_data[65:2], zero pad

  virtual_msr_register_file_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // local copy of the configuration, mirrored from every register write
  logic        pr_syscall_en = 1'b0;
  logic        pr_tsc_aux_en = 1'b0;
  logic [6:0]  pr_addr_width = vmsr_pkg::ADDR_WIDTH_RESET;
  logic [63:0] pr_dbg_mask   = '0;
  logic        pr_smm_mode   = 1'b0;
  logic        pr_paging_on  = 1'b0;
  logic [63:0] pr_fs_base    = '0;
  logic [63:0] pr_gs_base    = '0;

  // local copy of the guest msr state
  logic [31:0] guest_cs      = '0;
  logic [63:0] guest_esp     = '0;
  logic [63:0] guest_eip     = '0;
  logic [63:0] guest_debugctl = '0;
  logic [63:0] guest_pat     = '0;
  logic [63:0] guest_efer    = '0;
  logic [63:0] guest_star    = '0;
  logic [63:0] guest_lstar   = '0;
  logic [63:0] guest_cstar   = '0;
  logic [63:0] guest_sfmask  = '0;
  logic [63:0] guest_kgsbase = '0;
  logic [63:0] guest_tsc_aux = '0;

  msr_result_t   pending_results[$];
  directed_row_t directed_rows[$];
  int            mismatch_count = 0;

  // sender and receiver pacing, set per phase
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;

  // typed-in expectation travelling with the beat now on the input
  bit          item_typed = 1'b0;
  msr_result_t item_want  = '0;

  // linear address width after saturation to 32..64
  function automatic int eff_width();
    if (pr_addr_width < 7'd32) return 32;
    if (pr_addr_width > 7'd64) return 64;
    return int'(pr_addr_width);
  endfunction

  function automatic bit msr_present(logic [31:0] idx, bit for_write);
    case (idx)
      vmsr_pkg::IDX_SEP_CS, vmsr_pkg::IDX_SYSENTER_ESP, vmsr_pkg::IDX_SYSENTER_EIP,
      vmsr_pkg::IDX_DEBUGCTL, vmsr_pkg::IDX_PAT, vmsr_pkg::IDX_EFER: return 1'b1;
      vmsr_pkg::IDX_FS_BASE, vmsr_pkg::IDX_GS_BASE: return !for_write;
      vmsr_pkg::IDX_STAR, vmsr_pkg::IDX_LSTAR, vmsr_pkg::IDX_CSTAR,
      vmsr_pkg::IDX_SFMASK, vmsr_pkg::IDX_KGSBASE: return pr_syscall_en;
      vmsr_pkg::IDX_TSC_AUX: return pr_tsc_aux_en;
      default: return 1'b0;
    endcase
  endfunction

  // per-register value check of a write or a check write
  function automatic bit value_ok(logic [31:0] idx, logic [63:0] v);
    int          w;
    int          i;
    logic [63:0] upper;
    logic [7:0]  pat_byte;
    bit          canon;
    bit          ok;
    w = eff_width();
    upper = v >> (w - 1);
    canon = (w >= 64) || (upper == 64'd0) || (upper == (ALL_ONES >> (w - 1)));
    ok = 1'b1;
    case (idx)
      vmsr_pkg::IDX_SFMASK, vmsr_pkg::IDX_TSC_AUX: ok = (v[63:32] == 32'd0);
      vmsr_pkg::IDX_SYSENTER_ESP, vmsr_pkg::IDX_SYSENTER_EIP, vmsr_pkg::IDX_LSTAR,
      vmsr_pkg::IDX_CSTAR, vmsr_pkg::IDX_KGSBASE: ok = canon;
      vmsr_pkg::IDX_DEBUGCTL: ok = ((v & ~pr_dbg_mask) == 64'd0);
      vmsr_pkg::IDX_PAT: begin
        for (i = 0; i < 8; i++) begin
          pat_byte = v[8*i +: 8];
          if (pat_byte == 8'd2 || pat_byte == 8'd3 || pat_byte > 8'd7) ok = 1'b0;
        end
      end
      vmsr_pkg::IDX_EFER: begin
        // reserved bits, and lme frozen while paging is on
        ok = ((v & ~vmsr_pkg::EFER_ALLOWED) == 64'd0) &&
             !(pr_paging_on && (v[vmsr_pkg::EFER_LME_BIT]
                                != guest_efer[vmsr_pkg::EFER_LME_BIT]));
      end
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  // performs one access on the local state and returns its result
  function automatic msr_result_t predict_access(msr_access_t a);
    msr_result_t r;
    r.status = vmsr_pkg::ST_OK;
    r.data   = '0;
    case (a.func)
      vmsr_pkg::FUNC_READ: begin
        if (!msr_present(a.idx, 1'b0)) begin
          r.status = vmsr_pkg::ST_INVALID;
        end else begin
          case (a.idx)
            vmsr_pkg::IDX_SEP_CS:       r.data = {32'd0, guest_cs};
            vmsr_pkg::IDX_SYSENTER_ESP: r.data = guest_esp;
            vmsr_pkg::IDX_SYSENTER_EIP: r.data = guest_eip;
            vmsr_pkg::IDX_DEBUGCTL:     r.data = guest_debugctl;
            vmsr_pkg::IDX_PAT:          r.data = guest_pat;
            vmsr_pkg::IDX_EFER:         r.data = guest_efer;
            vmsr_pkg::IDX_STAR:         r.data = guest_star;
            vmsr_pkg::IDX_LSTAR:        r.data = guest_lstar;
            vmsr_pkg::IDX_CSTAR:        r.data = guest_cstar;
            vmsr_pkg::IDX_SFMASK:       r.data = guest_sfmask;
            vmsr_pkg::IDX_FS_BASE:      r.data = pr_fs_base;
            vmsr_pkg::IDX_GS_BASE:      r.data = pr_gs_base;
            vmsr_pkg::IDX_KGSBASE:      r.data = guest_kgsbase;
            vmsr_pkg::IDX_TSC_AUX:      r.data = guest_tsc_aux;
            default:                    r.data = '0;
          endcase
        end
      end
      vmsr_pkg::FUNC_WRITE: begin
        // fs/gs base are not present for writing, so every present index has storage
        if (!msr_present(a.idx, 1'b1) || !value_ok(a.idx, a.val)) begin
          r.status = vmsr_pkg::ST_INVALID;
        end else begin
          case (a.idx)
            vmsr_pkg::IDX_SEP_CS:       guest_cs = a.val[31:0];
            vmsr_pkg::IDX_SYSENTER_ESP: guest_esp = a.val;
            vmsr_pkg::IDX_SYSENTER_EIP: guest_eip = a.val;
            vmsr_pkg::IDX_DEBUGCTL:     guest_debugctl = a.val;
            vmsr_pkg::IDX_PAT:          guest_pat = a.val;
            vmsr_pkg::IDX_EFER:         guest_efer = (a.val & ~vmsr_pkg::EFER_LMA)
                                                   | (guest_efer & vmsr_pkg::EFER_LMA);
            vmsr_pkg::IDX_STAR:         guest_star = a.val;
            vmsr_pkg::IDX_LSTAR:        guest_lstar = a.val;
            vmsr_pkg::IDX_CSTAR:        guest_cstar = a.val;
            vmsr_pkg::IDX_SFMASK:       guest_sfmask = a.val;
            vmsr_pkg::IDX_KGSBASE:      guest_kgsbase = a.val;
            vmsr_pkg::IDX_TSC_AUX:      guest_tsc_aux = a.val;
            default:                    ;
          endcase
        end
      end
      default: begin
        // check read and check write never touch the state
        if (a.smm != pr_smm_mode) begin
          r.status = vmsr_pkg::ST_INVALID;
        end else if (!msr_present(a.idx, a.func == vmsr_pkg::FUNC_CHK_WRITE)) begin
          r.status = vmsr_pkg::ST_NOTSUP;
        end else if (a.func == vmsr_pkg::FUNC_CHK_WRITE && !value_ok(a.idx, a.val)) begin
          r.status = vmsr_pkg::ST_INVALID;
        end
      end
    endcase
    return r;
  endfunction

  // scoreboard: the input beat is handled before the output beat, since a result
  // can never leave in the same cycle its access was taken
  msr_access_t seen_acc;
  msr_result_t seen_res;
  msr_result_t want_res;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        seen_acc.func = s_tdata[1:0];
        seen_acc.idx  = s_tdata[33:2];
        seen_acc.val  = s_tdata[97:34];
        seen_acc.smm  = s_tuser;
        want_res = predict_access(seen_acc);
        if (item_typed) want_res = item_want;
        pending_results.push_back(want_res);
      end
      if (m_tvalid && m_tready) begin
        seen_res.status = m_tdata[1:0];
        seen_res.data   = m_tdata[65:2];
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got status %0d data %h",
                   $time, seen_res.status, seen_res.data);
          mismatch_count++;
        end else begin
          want_res = pending_results.pop_front();
          if (seen_res.status !== want_res.status || seen_res.data !== want_res.data) begin
            $display("%0t: result mismatch, expected status %0d data %h, got status %0d data %h",
                     $time, want_res.status, want_res.data, seen_res.status, seen_res.data);
            mismatch_count++;
          end
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  int hold_cnt;

  initial begin
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        m_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < 150; hold_cnt++) @(negedge clk);
        hold_done = 1'b1;
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // generous ceiling on the whole run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // offers one access and returns at the falling edge after its beat
  task automatic send_access(msr_access_t a, bit typed, msr_result_t want);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= {6'd0, a.val, a.idx, a.func};
    s_tuser    <= a.smm;
    item_typed = typed;
    item_want  = want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      vmsr_pkg::CFG_SYSCALL_EN:   pr_syscall_en = data[0];
      vmsr_pkg::CFG_TSC_AUX_EN:   pr_tsc_aux_en = data[0];
      vmsr_pkg::CFG_ADDR_WIDTH:   pr_addr_width = data[6:0];
      vmsr_pkg::CFG_DEBUGCTL_MSK: pr_dbg_mask = data;
      vmsr_pkg::CFG_SMM_MODE:     pr_smm_mode = data[0];
      vmsr_pkg::CFG_PAGING_ON:    pr_paging_on = data[0];
      vmsr_pkg::CFG_FS_BASE:      pr_fs_base = data;
      vmsr_pkg::CFG_GS_BASE:      pr_gs_base = data;
      default:                    ;
    endcase
    @(negedge clk);
  endtask

  // drains the block, rewrites every register, then sets the pacing
  task automatic set_phase(bit syscall_en, bit tsc_aux_en, logic [6:0] addr_width,
                           logic [63:0] dbg_mask, bit smm_mode, bit paging_on,
                           logic [63:0] fs_base, logic [63:0] gs_base,
                           int idle, int stall);
    s_tvalid <= 1'b0;
    wait_results_done();
    repeat (4) @(negedge clk);
    write_reg(vmsr_pkg::CFG_SYSCALL_EN, {63'd0, syscall_en});
    write_reg(vmsr_pkg::CFG_TSC_AUX_EN, {63'd0, tsc_aux_en});
    write_reg(vmsr_pkg::CFG_ADDR_WIDTH, {57'd0, addr_width});
    write_reg(vmsr_pkg::CFG_DEBUGCTL_MSK, dbg_mask);
    write_reg(vmsr_pkg::CFG_SMM_MODE, {63'd0, smm_mode});
    write_reg(vmsr_pkg::CFG_PAGING_ON, {63'd0, paging_on});
    write_reg(vmsr_pkg::CFG_FS_BASE, fs_base);
    write_reg(vmsr_pkg::CFG_GS_BASE, gs_base);
    cfg_we <= 1'b0;
    idle_pct  = idle;
    stall_pct = stall;
    @(negedge clk);
  endtask

  // mostly well-formed accesses on decoded indices, the rest noise
  task automatic run_random(int count);
    msr_access_t acc;
    logic [63:0] raw;
    int          w;
    int          b;
    int          n;
    for (n = 0; n < count; n++) begin
      raw = {$urandom, $urandom};
      acc.func = 2'($urandom_range(3));
      case ($urandom_range(9))
        0: acc.idx = $urandom;
        1: acc.idx = KNOWN_MSRS[$urandom_range(13)] ^ (32'd1 << $urandom_range(31));
        default: acc.idx = KNOWN_MSRS[$urandom_range(13)];
      endcase
      if ($urandom_range(3) == 0) begin
        acc.val = raw;
      end else if ($urandom_range(9) == 0) begin
        acc.val = $urandom_range(1) ? ALL_ONES : 64'd0;
      end else begin
        case (acc.idx)
          vmsr_pkg::IDX_SYSENTER_ESP, vmsr_pkg::IDX_SYSENTER_EIP, vmsr_pkg::IDX_LSTAR,
          vmsr_pkg::IDX_CSTAR, vmsr_pkg::IDX_KGSBASE: begin
            // sign-extend from the top address bit
            w = eff_width();
            if (w >= 64) acc.val = raw;
            else if (raw[w-1]) acc.val = raw | (ALL_ONES << (w - 1));
            else acc.val = raw & ~(ALL_ONES << (w - 1));
          end
          vmsr_pkg::IDX_PAT: begin
            for (b = 0; b < 8; b++) acc.val[8*b +: 8] = PAT_TYPES[$urandom_range(5)];
          end
          vmsr_pkg::IDX_DEBUGCTL: acc.val = raw & pr_dbg_mask;
          vmsr_pkg::IDX_SFMASK, vmsr_pkg::IDX_TSC_AUX: acc.val = {32'd0, raw[31:0]};
          vmsr_pkg::IDX_EFER:     acc.val = raw & vmsr_pkg::EFER_ALLOWED;
          default:                acc.val = raw;
        endcase
      end
      acc.smm = ($urandom_range(99) < 85) ? pr_smm_mode : ~pr_smm_mode;
      send_access(acc, 1'b0, '0);
    end
  endtask

  task automatic add_row(logic [1:0] f, logic [31:0] idx, logic [63:0] v, bit smm,
                         bit typed, logic [1:0] st, logic [63:0] d);
    directed_row_t row;
    row.acc.func    = f;
    row.acc.idx     = idx;
    row.acc.val     = v;
    row.acc.smm     = smm;
    row.typed       = typed;
    row.want.status = st;
    row.want.data   = d;
    directed_rows.push_back(row);
  endtask

  initial begin
    // reset configuration: syscall group and tsc_aux absent, width 48, empty mask
    add_row(vmsr_pkg::FUNC_READ, vmsr_pkg::IDX_SEP_CS, '0, 1'b0, 1'b1,
            vmsr_pkg::ST_OK, '0);
    add_row(vmsr_pkg::FUNC_READ, vmsr_pkg::IDX_STAR, '0, 1'b0, 1'b1,
            vmsr_pkg::ST_INVALID, '0);
    add_row(vmsr_pkg::FUNC_READ, vmsr_pkg::IDX_TSC_AUX, '0, 1'b0, 1'b1,
            vmsr_pkg::ST_INVALID, '0);
    add_row(vmsr_pkg::FUNC_READ, vmsr_pkg::IDX_FS_BASE, '0, 1'b0, 1'b1,
            vmsr_pkg::ST_OK, '0);
    add_row(vmsr_pkg::FUNC_WRITE, vmsr_pkg::IDX_GS_BASE, ALL_ONES, 1'b0, 1'b1,
            vmsr_pkg::ST_INVALID, '0);
    add_row(vmsr_pkg::FUNC_READ, 32'hffff_ffff, ALL_ONES, 1'b1, 1'b1,
            vmsr_pkg::ST_INVALID, '0);
    // the cs selector keeps only the low half
    add_row(vmsr_pkg::FUNC_WRITE, vmsr_pkg::IDX_SEP_CS, ALL_ONES, 1'b0, 1'b1,
            vmsr_pkg::ST_OK, '0);
    add_row(vmsr_pkg::FUNC_READ, vmsr_pkg::IDX_SEP_CS, '0, 1'b0, 1'b1,
            vmsr_pkg::ST_OK, 64'h0000_0000_ffff_ffff);
    // canonical edges at 48 bits
    add_row(vmsr_pkg::FUNC_WRITE, vmsr_pkg::IDX_SYSENTER_ESP, 64'h0000_7fff_ffff_ffff,
            1'b0, 1'b0, vmsr_pkg::ST_OK, '0);
    add_row(vmsr_pkg::FUNC_WRITE, vmsr_pkg::IDX_SYSENTER_EIP, 64'h0000_8000_0000_0000,
            1'b0, 1'b1, vmsr_pkg::ST_INVALID, '0);
    add_row(vmsr_pkg::FUNC_WRITE, vmsr_pkg::IDX_SYSENTER_EIP, 64'hffff_8000_0000_0000,
            1'b0, 1'b0, vmsr_pkg::ST_OK, '0);
    add_row(vmsr_pkg::FUNC_READ, vmsr_pkg::IDX_SYSENTER_EIP, '0, 1'b0, 1'b0,
            vmsr_pkg::ST_OK, '0);
    add_row(vmsr_pkg::FUNC_WRITE, vmsr_pkg::IDX_DEBUGCTL, 64'd1, 1'b0, 1'b1,
            vmsr_pkg::ST_INVALID, '0);
    add_row(vmsr_pkg::FUNC_WRITE, vmsr_pkg::IDX_DEBUGCTL, 64'd0, 1'b0, 1'b1,
            vmsr_pkg::ST_OK, '0);
    // pat types: all legal, then a reserved type, then an out-of-range byte on top
    add_row(vmsr_pkg::FUNC_WRITE, vmsr_pkg::IDX_PAT, 64'h0706_0504_0100_0706, 1'b0, 1'b0,
            vmsr_pkg::ST_OK, '0);
    add_row(vmsr_pkg::FUNC_WRITE, vmsr_pkg::IDX_PAT, 64'h0000_0000_0000_0002, 1'b0, 1'b1,
            vmsr_pkg::ST_INVALID, '0);
    add_row(vmsr_pkg::FUNC_WRITE, vmsr_pkg::IDX_PAT, 64'h0800_0000_0000_0000, 1'b0, 1'b1,
            vmsr_pkg::ST_INVALID, '0);
    // efer: lma is dropped on write, reserved bits rejected
    add_row(vmsr_pkg::FUNC_WRITE, vmsr_pkg::IDX_EFER, vmsr_pkg::EFER_ALLOWED, 1'b0, 1'b1,
            vmsr_pkg::ST_OK, '0);
    add_row(vmsr_pkg::FUNC_READ, vmsr_pkg::IDX_EFER, '0, 1'b0, 1'b1,
            vmsr_pkg::ST_OK, 64'h0000_0000_0000_0901);
    add_row(vmsr_pkg::FUNC_WRITE, vmsr_pkg::IDX_EFER, 64'd2, 1'b0, 1'b1,
            vmsr_pkg::ST_INVALID, '0);
    // check operations: smm mismatch, absent index, bad value, read-only, good value
    add_row(vmsr_pkg::FUNC_CHK_READ, vmsr_pkg::IDX_SEP_CS, '0, 1'b1, 1'b1,
            vmsr_pkg::ST_INVALID, '0);
    add_row(vmsr_pkg::FUNC_CHK_READ, 32'h0000_1234, '0, 1'b0, 1'b1,
            vmsr_pkg::ST_NOTSUP, '0);
    add_row(vmsr_pkg::FUNC_CHK_WRITE, vmsr_pkg::IDX_EFER, 64'd2, 1'b0, 1'b1,
            vmsr_pkg::ST_INVALID, '0);
    add_row(vmsr_pkg::FUNC_CHK_WRITE, vmsr_pkg::IDX_FS_BASE, '0, 1'b0, 1'b1,
            vmsr_pkg::ST_NOTSUP, '0);
    add_row(vmsr_pkg::FUNC_CHK_WRITE, vmsr_pkg::IDX_PAT, 64'h0000_0000_0000_0007, 1'b0, 1'b1,
            vmsr_pkg::ST_OK, '0);

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].want);
    end

    // everything present, back-to-back
    set_phase(1'b1, 1'b1, 7'd48, {$urandom, $urandom}, 1'b0, 1'b0,
              {$urandom, $urandom}, {$urandom, $urandom}, 0, 0);
    run_random(90);
    // narrowest width, full mask, paging locks lme, sender idles
    set_phase(1'b1, 1'b0, 7'd32, ALL_ONES, 1'b1, 1'b1, ALL_ONES, '0, 64, 0);
    run_random(90);
    // widest width, syscall group gone, receiver stalls
    set_phase(1'b0, 1'b1, 7'd64, '0, 1'b0, 1'b1, '0, ALL_ONES, 0, 64);
    run_random(90);
    set_phase(1'b1, 1'b1, 7'd57, {$urandom, $urandom}, 1'b1, 1'b0,
              {$urandom, $urandom}, {$urandom, $urandom}, 9, 9);
    run_random(90);
    // receiver holds off while the sender keeps pushing, so the input backs up
    set_phase(1'b1, 1'b1, 7'd40, {$urandom, $urandom}, 1'b0, 1'b1,
              {$urandom, $urandom}, {$urandom, $urandom}, 0, 0);
    hold_request = 1'b1;
    run_random(90);
    // width below range saturates to 32; sender pauses for a full drain midway
    set_phase(1'b1, 1'b1, 7'd16, {$urandom, $urandom}, 1'b1, 1'b0,
              {$urandom, $urandom}, {$urandom, $urandom}, 0, 0);
    run_random(45);
    s_tvalid <= 1'b0;
    wait_results_done();
    run_random(45);
    // width above range saturates to 64
    set_phase(1'b1, 1'b1, 7'd127, {$urandom, $urandom}, 1'b0, 1'b1,
              {$urandom, $urandom}, {$urandom, $urandom}, 64, 0);
    run_random(90);
    set_phase(1'b0, 1'b0, 7'd33, {$urandom, $urandom}, 1'b1, 1'b1,
              {$urandom, $urandom}, {$urandom, $urandom}, 9, 9);
    run_random(90);

    s_tvalid <= 1'b0;
    wait_results_done();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
